[src/tklt_pkg.sv]
package tklt_pkg;

   localparam int KEY_W  = 32;
   localparam int PAY_W  = 32;
   localparam int RANK_W = 4;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_READ   = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } entry_type;

   // what one cell hands to its right-hand neighbor
   typedef struct packed {
      entry_type entry;
      logic      ge;      // this cell keeps its entry on the current insert
   } link_type;

endpackage

[src/tklt_cell.sv]
module tklt_cell
   import tklt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             ins_en,
   input  logic [KEY_W-1:0] new_key,
   input  logic [PAY_W-1:0] new_payload,
   input  link_type         prev_link,
   output link_type         link
);

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [PAY_W-1:0] payload_ff, payload_in;
   logic             ge;

   assign ge = valid_ff && (key_ff >= new_key);

   always_comb begin
      valid_in   = valid_ff;
      key_in     = key_ff;
      payload_in = payload_ff;
      if (ins_en && !ge) begin
         if (prev_link.ge) begin
            // insertion point: left neighbor stays, this cell takes the new word
            valid_in   = 1'b1;
            key_in     = new_key;
            payload_in = new_payload;
         end else begin
            valid_in   = prev_link.entry.valid;
            key_in     = prev_link.entry.key;
            payload_in = prev_link.entry.payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign link.entry.valid   = valid_ff;
   assign link.entry.key     = key_ff;
   assign link.entry.payload = payload_ff;
   assign link.ge            = ge;

endmodule

[src/top_k_largest_tracker.sv]
// Channel  Dir  tuser             tdata (low bit first)
// req_     in   req_type          new_key, new_payload, read_rank
// rsp_     out  -                 accepted, placed_rank, entry_valid, entry_key,
//                                 entry_payload, held_count
//
// One word per cycle while rsp_ is not stalled: the cell row compares and shifts
// in the accept cycle; the result word is registered and is on rsp_ the next cycle.
// Reset (synchronous, active high) empties the row; no clearing pass.
// A stalled rsp_ holds its word; req_tready stays high while the held word
// is being taken.
module top_k_largest_tracker
   import tklt_pkg::*;
#(
   parameter int KEEP_DEPTH = 10
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // req_type
   input  logic [71:0] req_tdata,   // new_key, new_payload, read_rank, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // accepted, placed_rank, entry_valid,
                                    // entry_key, entry_payload, held_count, zero fill
);

   localparam int CNT_W = $clog2(KEEP_DEPTH + 1);
   localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

   logic             req_fire;
   req_kind_type     req_kind;
   logic [KEY_W-1:0] new_key;
   logic [PAY_W-1:0] new_payload;
   logic [RANK_W-1:0] read_rank;
   logic             ins_en;

   link_type         links [KEEP_DEPTH:0];
   logic             acc;
   logic [CNT_W-1:0] pos;
   logic [CNT_W-1:0] count_ff, count_in;
   entry_type        rd_entry;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [79:0]      rsp_data_ff, rsp_data_in;

   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign req_fire    = req_tvalid && req_tready;
   assign req_kind    = req_kind_type'(req_tuser[0]);
   assign new_key     = req_tdata[31:0];
   assign new_payload = req_tdata[63:32];
   assign read_rank   = req_tdata[67:64];
   assign ins_en      = req_fire && (req_kind == REQ_INSERT);

   // head of the row: always "keeps", so cell 0 takes a new key it does not beat
   assign links[0].entry = '0;
   assign links[0].ge    = 1'b1;

   for (genvar i = 0; i < KEEP_DEPTH; i++) begin : g_cell
      tklt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ins_en      (ins_en),
         .new_key     (new_key),
         .new_payload (new_payload),
         .prev_link   (links[i]),
         .link        (links[i+1])
      );
   end

   assign acc = !links[KEEP_DEPTH].ge;

   always_comb begin
      pos = '0;
      for (int i = 0; i < KEEP_DEPTH; i++) begin
         if (links[i].ge && !links[i+1].ge) begin
            pos = CNT_W'(i);
         end
      end
   end

   always_comb begin
      rd_entry = '0;
      for (int i = 0; i < KEEP_DEPTH; i++) begin
         if (CMP_W'(read_rank) == CMP_W'(i) && links[i+1].entry.valid) begin
            rd_entry = links[i+1].entry;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ins_en && acc && (count_ff != CNT_W'(KEEP_DEPTH))) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (req_kind == REQ_INSERT) begin
            rsp_data_in[0]   = acc;
            rsp_data_in[4:1] = acc ? RANK_W'(pos) : '0;
         end else begin
            rsp_data_in[5]     = rd_entry.valid;
            rsp_data_in[37:6]  = rd_entry.key;
            rsp_data_in[69:38] = rd_entry.payload;
         end
         rsp_data_in[73:70] = RANK_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
